// File: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on aclk, off while aresetn is low
`define QTS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("qts assertion failed");

// checked on aclk, also during reset
`define QTS_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("qts reset assertion failed");

`endif

// File: src/qts_pkg.sv
// types, codes and arithmetic helpers of the quintic trajectory sequencer
`default_nettype none

package qts_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int AXES_DEF         = 4;
    localparam int POLY_TERMS       = 6;

    localparam logic [1:0] REQ_COEF   = 2'd0;
    localparam logic [1:0] REQ_TIMING = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    localparam logic [1:0] CFG_SEG_COUNT = 2'd0;
    localparam logic [1:0] CFG_LOOP_EN   = 2'd1;
    localparam logic [1:0] CFG_LOOP_SEG  = 2'd2;

    localparam logic [30:0] TICK_DT  = 31'd6554;
    localparam logic [30:0] TIME_MAX = 31'h7fffffff;
    localparam logic [30:0] P_ONE    = 31'd65536;
    localparam logic signed [32:0] END_TOL = 33'sd7;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [5:0]         segment_index;
        logic [1:0]         axis_index;
        logic [2:0]         power_index;
        logic signed [31:0] load_value;
        logic [15:0]        dwell_ticks;
    } req_t;

    typedef struct packed {
        logic [1:0]         axis_id;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] acceleration;
        logic [6:0]         current_segment;
        logic [30:0]        segment_time;
        logic               last_of_tick;
    } result_t;

    typedef struct packed {
        logic       load_coef;
        logic       load_timing;
        logic       tick_pre;
        logic       pow_mul;
        logic       pow_wr;
        logic [2:0] pow_k;
        logic       term_issue;
        logic [2:0] term_k;
        logic [1:0] term_d;
        logic [1:0] axis;
        logic       acc_clr;
        logic       out_load;
        logic       out_last;
        logic       seg_end;
    } cmd_t;

    typedef struct packed {
        logic go;
        logic out_free;
    } stat_t;

    // derivative factor: 1, k or k*(k-1)
    function automatic logic [4:0] term_factor(input logic [2:0] k, input logic [1:0] d);
        logic [4:0] f;
        unique case (d)
            2'd0:    f = 5'd1;
            2'd1:    f = {2'b00, k};
            default: f = 5'(int'(k) * (int'(k) - 1));
        endcase
        return f;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
        logic signed [31:0] r;
        if (v > 56'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -56'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/qts_ctrl.sv
// sequencing state machine: loads, tick preamble, powers, terms per axis, emit, segment end
`default_nettype none

module qts_ctrl #(
    parameter int AXES = qts_pkg::AXES_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [1:0]    req_type,
    input  wire qts_pkg::stat_t stat,
    output qts_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE,
        ST_CHECK,
        ST_POW_MUL,
        ST_POW_WR,
        ST_TERM,
        ST_DRAIN,
        ST_EMIT,
        ST_SEG_END
    } state_t;

    localparam logic [2:0] K_LAST = 3'(qts_pkg::POLY_TERMS - 1);

    state_t     state_reg;
    logic [2:0] k_reg;
    logic [1:0] d_reg;
    logic [1:0] axis_reg;
    logic       drain_reg;
    logic       accept;
    logic       axis_last;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign axis_last = (int'(axis_reg) == AXES - 1);

    always_comb begin
        cmd             = '0;
        cmd.load_coef   = accept && (req_type == qts_pkg::REQ_COEF);
        cmd.load_timing = accept && (req_type == qts_pkg::REQ_TIMING);
        cmd.tick_pre    = (state_reg == ST_PRE);
        cmd.pow_mul     = (state_reg == ST_POW_MUL);
        cmd.pow_wr      = (state_reg == ST_POW_WR);
        cmd.pow_k       = k_reg;
        cmd.term_issue  = (state_reg == ST_TERM);
        cmd.term_k      = k_reg;
        cmd.term_d      = d_reg;
        cmd.axis        = axis_reg;
        cmd.out_load    = (state_reg == ST_EMIT) && stat.out_free;
        cmd.acc_clr     = cmd.out_load || (state_reg == ST_PRE);
        cmd.out_last    = axis_last;
        cmd.seg_end     = (state_reg == ST_SEG_END);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            d_reg     <= '0;
            axis_reg  <= '0;
            drain_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && req_type == qts_pkg::REQ_TICK) begin
                        state_reg <= ST_PRE;
                    end
                end
                ST_PRE: begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    k_reg     <= 3'd1;
                    state_reg <= stat.go ? ST_POW_MUL : ST_IDLE;
                end
                ST_POW_MUL: begin
                    state_reg <= ST_POW_WR;
                end
                ST_POW_WR: begin
                    if (k_reg == K_LAST) begin
                        k_reg     <= '0;
                        d_reg     <= '0;
                        axis_reg  <= '0;
                        state_reg <= ST_TERM;
                    end else begin
                        k_reg     <= k_reg + 3'd1;
                        state_reg <= ST_POW_MUL;
                    end
                end
                ST_TERM: begin
                    // walk (k, d) with d up to min(k, 2)
                    if (d_reg < 2'd2 && {1'b0, d_reg} < k_reg) begin
                        d_reg <= d_reg + 2'd1;
                    end else begin
                        d_reg <= '0;
                        if (k_reg == K_LAST) begin
                            drain_reg <= 1'b0;
                            state_reg <= ST_DRAIN;
                        end else begin
                            k_reg <= k_reg + 3'd1;
                        end
                    end
                end
                ST_DRAIN: begin
                    // read and multiply stages empty out
                    if (drain_reg) begin
                        state_reg <= ST_EMIT;
                    end else begin
                        drain_reg <= 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (stat.out_free) begin
                        if (axis_last) begin
                            state_reg <= ST_SEG_END;
                        end else begin
                            axis_reg  <= axis_reg + 2'd1;
                            k_reg     <= '0;
                            d_reg     <= '0;
                            state_reg <= ST_TERM;
                        end
                    end
                end
                ST_SEG_END: begin
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/qts_datapath.sv
// configuration, stores, play state, shared multiplier, accumulators and result register
`default_nettype none

module qts_datapath #(
    parameter int MAX_SEGMENTS = qts_pkg::MAX_SEGMENTS_DEF,
    parameter int AXES         = qts_pkg::AXES_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire qts_pkg::cmd_t  cmd,
    output qts_pkg::stat_t      stat,
    input  wire qts_pkg::req_t  s_data,
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [6:0]     cfg_wdata,
    input  wire logic           m_ready,
    output logic                m_valid,
    output qts_pkg::result_t    m_data
);

    localparam int COEF_DEPTH = MAX_SEGMENTS * AXES * qts_pkg::POLY_TERMS;
    localparam int CA_W       = $clog2(COEF_DEPTH);
    localparam int SEG_W      = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    // configuration
    logic [6:0] seg_count_reg;
    logic       loop_en_reg;
    logic [5:0] loop_seg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_count_reg <= '0;
            loop_en_reg   <= 1'b0;
            loop_seg_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                qts_pkg::CFG_SEG_COUNT: seg_count_reg <= cfg_wdata;
                qts_pkg::CFG_LOOP_EN:   loop_en_reg   <= cfg_wdata[0];
                qts_pkg::CFG_LOOP_SEG:  loop_seg_reg  <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // stores
    logic signed [31:0] coef_mem [0:COEF_DEPTH-1];
    logic signed [31:0] dur_mem  [0:MAX_SEGMENTS-1];
    logic [15:0]        hold_mem [0:MAX_SEGMENTS-1];
    logic signed [31:0] coef_rd_reg;
    logic signed [31:0] dur_rd_reg;
    logic [15:0]        hold_rd_reg;
    logic [CA_W-1:0]    coef_wr_addr;
    logic [CA_W-1:0]    coef_rd_addr;
    logic               coef_ok;
    logic               seg_ok;

    // play state
    logic [6:0]  seg_reg, seg_next;
    logic [30:0] t_reg, t_next;
    logic        dw_reg, dw_next;
    logic [15:0] dl_reg, dl_next;
    logic        fin_reg, fin_next;

    assign coef_ok = (int'(s_data.segment_index) < MAX_SEGMENTS)
                  && (int'(s_data.axis_index) < AXES)
                  && (int'(s_data.power_index) < qts_pkg::POLY_TERMS);
    assign seg_ok  = (int'(s_data.segment_index) < MAX_SEGMENTS);
    assign coef_wr_addr = CA_W'((int'(s_data.segment_index) * AXES + int'(s_data.axis_index))
                                * qts_pkg::POLY_TERMS + int'(s_data.power_index));
    assign coef_rd_addr = CA_W'((int'(seg_reg) * AXES + int'(cmd.axis))
                                * qts_pkg::POLY_TERMS + int'(cmd.term_k));

    always_ff @(posedge aclk) begin
        if (cmd.load_coef && coef_ok) begin
            coef_mem[coef_wr_addr] <= s_data.load_value;
        end
        coef_rd_reg <= coef_mem[coef_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_timing && seg_ok) begin
            dur_mem[SEG_W'(s_data.segment_index)]  <= s_data.load_value;
            hold_mem[SEG_W'(s_data.segment_index)] <= s_data.dwell_ticks;
        end
        // play segment is below the count in use whenever these are consumed
        dur_rd_reg  <= dur_mem[SEG_W'(seg_reg)];
        hold_rd_reg <= hold_mem[SEG_W'(seg_reg)];
    end

    // tick preamble and segment end
    logic [6:0]         cnt;
    logic [31:0]        tsum;
    logic signed [32:0] t_ext;
    logic signed [32:0] dur_ext;
    logic               end_hit;

    assign cnt     = (int'(seg_count_reg) > MAX_SEGMENTS) ? 7'(MAX_SEGMENTS) : seg_count_reg;
    assign t_ext   = $signed({2'b00, t_reg});
    assign dur_ext = $signed({dur_rd_reg[31], dur_rd_reg});
    assign end_hit = (t_ext + qts_pkg::END_TOL) >= dur_ext;

    always_comb begin
        seg_next = seg_reg;
        t_next   = t_reg;
        dw_next  = dw_reg;
        dl_next  = dl_reg;
        fin_next = fin_reg;
        tsum     = '0;
        if (cmd.tick_pre) begin
            if (dw_reg) begin
                if (dl_reg <= 16'd1) begin
                    dw_next  = 1'b0;
                    dl_next  = '0;
                    seg_next = seg_reg + 7'd1;
                    t_next   = '0;
                end else begin
                    dl_next = dl_reg - 16'd1;
                end
            end
            // end of trajectory: loop back or stop
            if (!fin_reg && seg_next >= cnt) begin
                t_next  = '0;
                dw_next = 1'b0;
                dl_next = '0;
                if (loop_en_reg && {1'b0, loop_seg_reg} < cnt) begin
                    seg_next = {1'b0, loop_seg_reg};
                end else begin
                    fin_next = 1'b1;
                end
            end
            if (!fin_next && !dw_next) begin
                tsum   = {1'b0, t_next} + {1'b0, qts_pkg::TICK_DT};
                t_next = tsum[31] ? qts_pkg::TIME_MAX : tsum[30:0];
            end
        end else if (cmd.seg_end && end_hit) begin
            if (hold_rd_reg != 16'd0) begin
                dw_next = 1'b1;
                dl_next = hold_rd_reg;
            end else begin
                seg_next = seg_reg + 7'd1;
                t_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg <= '0;
            t_reg   <= '0;
            dw_reg  <= 1'b0;
            dl_reg  <= '0;
            fin_reg <= 1'b0;
        end else begin
            seg_reg <= seg_next;
            t_reg   <= t_next;
            dw_reg  <= dw_next;
            dl_reg  <= dl_next;
            fin_reg <= fin_next;
        end
    end

    // term pipeline: read, multiply, accumulate
    logic        v1_reg, v2_reg;
    logic [2:0]  k1_reg, k2_reg;
    logic [1:0]  d1_reg, d2_reg;
    logic [30:0] p_reg [1:qts_pkg::POLY_TERMS-1];
    logic [2:0]  p_idx;
    logic [30:0] p_sel;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_full;
    logic signed [63:0] prod_reg;
    logic signed [63:0] pr_sum;
    logic [46:0]        p_wide;
    logic [30:0]        p_new;
    logic signed [47:0] rnd;
    logic [4:0]         fct;
    logic signed [53:0] term_p;
    logic signed [55:0] term_x;
    logic signed [55:0] pos_reg, vel_reg, acc_reg;

    assign p_idx    = v1_reg ? (k1_reg - {1'b0, d1_reg}) : (cmd.pow_k - 3'd1);
    assign p_sel    = (p_idx == 3'd0) ? qts_pkg::P_ONE : p_reg[p_idx];
    assign mul_a    = v1_reg ? $signed({coef_rd_reg[31], coef_rd_reg}) : $signed({2'b00, t_reg});
    assign mul_b    = $signed({2'b00, p_sel});
    assign mul_full = mul_a * mul_b;

    // round half up, then shift out the fraction
    assign pr_sum = prod_reg + 64'sd32768;
    assign p_wide = pr_sum[62:16];
    assign p_new  = (|p_wide[46:31]) ? qts_pkg::TIME_MAX : p_wide[30:0];
    assign rnd    = pr_sum[63:16];
    assign fct    = qts_pkg::term_factor(k2_reg, d2_reg);
    assign term_p = rnd * $signed({1'b0, fct});
    assign term_x = {{2{term_p[53]}}, term_p};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.term_issue;
            v2_reg <= v1_reg;
        end
        k1_reg <= cmd.term_k;
        d1_reg <= cmd.term_d;
        k2_reg <= k1_reg;
        d2_reg <= d1_reg;
        if (v1_reg || cmd.pow_mul) begin
            prod_reg <= mul_full[63:0];
        end
        if (cmd.pow_wr) begin
            p_reg[cmd.pow_k] <= p_new;
        end
        if (cmd.acc_clr) begin
            pos_reg <= '0;
            vel_reg <= '0;
            acc_reg <= '0;
        end else if (v2_reg) begin
            unique case (d2_reg)
                2'd0:    pos_reg <= pos_reg + term_x;
                2'd1:    vel_reg <= vel_reg + term_x;
                default: acc_reg <= acc_reg + term_x;
            endcase
        end
    end

    // result register
    logic             m_valid_reg;
    qts_pkg::result_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_data_reg.axis_id         <= cmd.axis;
            m_data_reg.position        <= qts_pkg::sat32(pos_reg);
            m_data_reg.velocity        <= qts_pkg::sat32(vel_reg);
            m_data_reg.acceleration    <= qts_pkg::sat32(acc_reg);
            m_data_reg.current_segment <= seg_reg;
            m_data_reg.segment_time    <= t_reg;
            m_data_reg.last_of_tick    <= cmd.out_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;
    assign stat.go       = !fin_reg && !dw_reg;
    assign stat.out_free = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

// File: src/quintic_trajectory_sequencer_top.sv
// top level of the quintic trajectory sequencer
//
//   channel  | ports                       | moves
//   ---------+-----------------------------+------------------------------------
//   s_       | s_valid s_ready s_data      | load or tick request
//   m_       | m_valid m_ready m_data      | one axis result (pos, vel, acc)
//   cfg_     | cfg_we cfg_index cfg_wdata  | segment_count, loop_enable, loop_segment
//
// an evaluating tick uses one shared 33x33 multiplier to form the five powers of t
// and then 15 terms per axis
// reset is synchronous, active low; the stores keep their contents
// a stalled result holds the sequencer in its emit step
`default_nettype none

module quintic_trajectory_sequencer_top #(
    parameter int MAX_SEGMENTS = qts_pkg::MAX_SEGMENTS_DEF,
    parameter int AXES         = qts_pkg::AXES_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire qts_pkg::req_t    s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output qts_pkg::result_t      m_data,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [6:0]       cfg_wdata
);

    qts_pkg::cmd_t  cmd;
    qts_pkg::stat_t stat;

    qts_ctrl #(
        .AXES(AXES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .req_type(s_data.req_type),
        .stat    (stat),
        .cmd     (cmd)
    );

    qts_datapath #(
        .MAX_SEGMENTS(MAX_SEGMENTS),
        .AXES        (AXES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_data   (s_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

// File: src/qts_checker.sv
// port-level checker for the sequencer and its bind
`default_nettype none

`include "assert_macros.svh"

module qts_checker #(
    parameter int AXES = qts_pkg::AXES_DEF
) (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_ready,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire qts_pkg::result_t m_data
);

    // a stalled result holds
    `QTS_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data))
    // nothing shown right after reset
    `QTS_ASSERT_RST(a_out_reset, !aresetn |=> !m_valid)
    // a tick is still running after an earlier axis leaves
    `QTS_ASSERT(a_busy_mid_tick, m_valid && m_ready && !m_data.last_of_tick |=> !s_ready)
    // the closing result of a tick belongs to the last axis
    `QTS_ASSERT(a_last_axis, m_valid && m_data.last_of_tick |-> int'(m_data.axis_id) == AXES - 1)

endmodule

bind quintic_trajectory_sequencer_top qts_checker #(
    .AXES(AXES)
) u_qts_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

`default_nettype wire
